@@ rtl/tss_pkg.sv @@
// Shared types, constants and saturation helpers for the tridiagonal solver.
// Used by tss_divider and tridiagonal_system_solver_core; no dependencies.
package tss_pkg;

    localparam int DATA_W    = 32;
    localparam int ROW_IDX_W = 6;

    typedef logic signed [DATA_W-1:0] fx_t;

    typedef struct packed {
        fx_t  value;
        logic clamped;
    } sat_t;

    typedef struct packed {
        logic start;
        fx_t  num;
        fx_t  den;
    } div_req_t;

    typedef struct packed {
        logic done;
        fx_t  quo;
        logic sat;
    } div_rsp_t;

    function automatic sat_t sat_wide(input logic signed [2*DATA_W-1:0] v);
        sat_t res;
        logic upper_ok;
        upper_ok = (v[2*DATA_W-1:DATA_W-1] == '0) || (v[2*DATA_W-1:DATA_W-1] == '1);
        if (upper_ok)
        begin
            res.value   = v[DATA_W-1:0];
            res.clamped = 1'b0;
        end
        else
        begin
            res.value   = v[2*DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};
            res.clamped = 1'b1;
        end
        return res;
    endfunction

    function automatic sat_t sat_sub(input fx_t a, input fx_t b);
        sat_t res;
        logic signed [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] != d[DATA_W-1])
        begin
            res.value   = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                    : {1'b0, {(DATA_W-1){1'b1}}};
            res.clamped = 1'b1;
        end
        else
        begin
            res.value   = d[DATA_W-1:0];
            res.clamped = 1'b0;
        end
        return res;
    endfunction

endpackage

@@ rtl/tss_divider.sv @@
// Iterative restoring divider: (num * 2^FRAC_BITS) / den, truncated and saturated.
// Depends on tss_pkg for the request and response structs.
module tss_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tss_pkg::div_req_t  req,
    output tss_pkg::div_rsp_t  rsp
);

    localparam int DW = tss_pkg::DATA_W + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam int W  = tss_pkg::DATA_W;

    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic [W-1:0]  rem_reg;
    logic [DW-1:0] dq_reg;
    logic [W-1:0]  dmag_reg;
    logic          neg_reg;
    logic          dzero_reg;
    logic          npos_reg;
    logic          nneg_reg;
    logic          done_reg;
    tss_pkg::fx_t  quo_reg;
    logic          sat_reg;

    logic [W:0]    trial;
    logic [W-1:0]  nmag;
    logic [W-1:0]  dmag;
    logic          big_pos;
    logic          big_neg;

    assign nmag    = req.num[W-1] ? W'(-req.num) : W'(req.num);
    assign dmag    = req.den[W-1] ? W'(-req.den) : W'(req.den);
    assign trial   = {rem_reg, dq_reg[DW-1]};
    assign big_pos = |dq_reg[DW-1:W-1];
    assign big_neg = (|dq_reg[DW-1:W]) || (dq_reg[W-1] && (|dq_reg[W-2:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= CW'(DW);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg   <= '0;
            dq_reg    <= {nmag, {FRAC_BITS{1'b0}}};
            dmag_reg  <= dmag;
            neg_reg   <= req.num[W-1] ^ req.den[W-1];
            dzero_reg <= (req.den == '0);
            npos_reg  <= !req.num[W-1] && (req.num != '0);
            nneg_reg  <= req.num[W-1];
        end
        else if (run_reg)
        begin
            if (cnt_reg != '0)
            begin
                if (trial >= {1'b0, dmag_reg})
                begin
                    rem_reg <= W'(trial - {1'b0, dmag_reg});
                    dq_reg  <= {dq_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[W-1:0];
                    dq_reg  <= {dq_reg[DW-2:0], 1'b0};
                end
            end
            else
            begin
                if (dzero_reg)
                begin
                    sat_reg <= 1'b1;
                    quo_reg <= npos_reg ? {1'b0, {(W-1){1'b1}}} :
                               nneg_reg ? {1'b1, {(W-1){1'b0}}} : '0;
                end
                else if (!neg_reg)
                begin
                    sat_reg <= big_pos;
                    quo_reg <= big_pos ? {1'b0, {(W-1){1'b1}}} : dq_reg[W-1:0];
                end
                else
                begin
                    sat_reg <= big_neg;
                    quo_reg <= big_neg ? {1'b1, {(W-1){1'b0}}} : -dq_reg[W-1:0];
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.sat  = sat_reg;

endmodule

@@ rtl/tridiagonal_system_solver_core.sv @@
// Top level of the Thomas tridiagonal solver: row memories, sweep sequencer, output stage.
// Depends on tss_pkg and two tss_divider instances.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid/in_ready  | sub_diag, main_diag, super_diag, rhs_value, last_row
//  out     | out_valid/out_ready| solution, row_index, last_result, pivot_fault
//
// The bit-serial dividers set the pace at which rows are taken; the first row of a
// system skips the read, multiply and numerator states and goes straight to the divisions.
// After the last row, each further solution goes through memory read, multiply and subtract.
// Reset clears the sequencer, row count and fault flag; no memory clearing is needed.
// A stalled result holds the block; no row is taken until back-substitution ends.
module tridiagonal_system_solver_core #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [tss_pkg::DATA_W-1:0]   sub_diag,
    input  logic signed [tss_pkg::DATA_W-1:0]   main_diag,
    input  logic signed [tss_pkg::DATA_W-1:0]   super_diag,
    input  logic signed [tss_pkg::DATA_W-1:0]   rhs_value,
    input  logic                                last_row,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tss_pkg::DATA_W-1:0]   solution,
    output logic [tss_pkg::ROW_IDX_W-1:0]       row_index,
    output logic                                last_result,
    output logic                                pivot_fault
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int W  = tss_pkg::DATA_W;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD   = 10'b0000000010,
        S_MUL1 = 10'b0000000100,
        S_MUL2 = 10'b0000001000,
        S_NUM  = 10'b0000010000,
        S_DIV  = 10'b0000100000,
        S_OUT  = 10'b0001000000,
        S_BRD  = 10'b0010000000,
        S_BMUL = 10'b0100000000,
        S_BSUB = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    tss_pkg::fx_t ms_mem [MAX_ROWS];
    tss_pkg::fx_t mr_mem [MAX_ROWS];
    tss_pkg::fx_t ms_rd_reg;
    tss_pkg::fx_t mr_rd_reg;

    logic [AW-1:0] row_count_reg;
    logic          fault_reg;
    logic [AW-1:0] i_reg;
    logic [AW-1:0] k_reg;
    logic          last_reg;
    tss_pkg::fx_t  a_reg, b_reg, c_reg, r_reg;
    tss_pkg::fx_t  pivot_reg;
    tss_pkg::fx_t  next_sol_reg;
    logic signed [2*W-1:0] prod_reg;

    logic          out_valid_reg;
    tss_pkg::fx_t  out_sol_reg;
    logic [AW-1:0] out_idx_reg;
    logic          out_fault_reg;

    logic          in_acc, out_acc;
    logic          forced;
    logic          last_eff;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic signed [2*W-1:0] prod_shift;
    tss_pkg::sat_t prod_sat;
    tss_pkg::sat_t diff_sat;
    tss_pkg::fx_t  diff_a;
    tss_pkg::div_req_t req;
    tss_pkg::div_rsp_t rsp_super, rsp_rhs;
    tss_pkg::div_req_t req_super, req_rhs;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid_reg && out_ready;
    assign forced    = (row_count_reg == AW'(MAX_ROWS - 1)) && !last_row;
    assign last_eff  = last_row || forced;

    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign prod_sat   = tss_pkg::sat_wide(prod_shift);
    always_comb
    begin
        unique case (state_reg)
            S_MUL2:  diff_a = b_reg;
            S_NUM:   diff_a = r_reg;
            default: diff_a = mr_rd_reg;
        endcase
    end
    assign diff_sat = tss_pkg::sat_sub(diff_a, prod_sat.value);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = k_reg - 1'b1;
        if (in_acc && (row_count_reg != '0))
        begin
            rd_en   = 1'b1;
            rd_addr = row_count_reg - 1'b1;
        end
        else if ((state_reg == S_OUT) && out_acc && (k_reg != '0))
        begin
            rd_en = 1'b1;
        end
    end

    assign mem_we = (state_reg == S_DIV) && rsp_super.done;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ms_mem[i_reg] <= rsp_super.quo;
            mr_mem[i_reg] <= rsp_rhs.quo;
        end
        if (rd_en)
        begin
            ms_rd_reg <= ms_mem[rd_addr];
            mr_rd_reg <= mr_mem[rd_addr];
        end
    end

    always_comb
    begin
        req.start = 1'b0;
        req.num   = c_reg;
        req.den   = pivot_reg;
        if (in_acc && (row_count_reg == '0))
        begin
            req.start = 1'b1;
            req.num   = last_eff ? '0 : super_diag;
            req.den   = main_diag;
        end
        else if (state_reg == S_NUM)
        begin
            req.start = 1'b1;
        end
    end

    always_comb
    begin
        req_super = req;
        req_rhs   = req;
        if (in_acc)
        begin
            req_rhs.num = rhs_value;
        end
        else
        begin
            req_rhs.num = diff_sat.value;
        end
    end

    tss_divider #(.FRAC_BITS(FRAC_BITS)) u_div_super (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_super),
        .rsp   (rsp_super)
    );

    tss_divider #(.FRAC_BITS(FRAC_BITS)) u_div_rhs (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_rhs),
        .rsp   (rsp_rhs)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_acc) state_next = (row_count_reg == '0) ? S_DIV : S_RD;
            S_RD:   state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_NUM;
            S_NUM:  state_next = S_DIV;
            S_DIV:  if (rsp_super.done) state_next = last_reg ? S_OUT : S_IDLE;
            S_OUT:  if (out_acc) state_next = (k_reg == '0) ? S_IDLE : S_BRD;
            S_BRD:  state_next = S_BMUL;
            S_BMUL: state_next = S_BSUB;
            S_BSUB: state_next = S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_count_reg <= '0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && forced)
                    begin
                        fault_reg <= 1'b1;
                    end
                end
                S_MUL2, S_NUM:
                begin
                    fault_reg <= fault_reg | prod_sat.clamped | diff_sat.clamped;
                end
                S_DIV:
                begin
                    if (rsp_super.done)
                    begin
                        fault_reg <= fault_reg | rsp_super.sat | rsp_rhs.sat;
                        if (last_reg)
                        begin
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            row_count_reg <= i_reg + 1'b1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_acc)
                    begin
                        out_valid_reg <= 1'b0;
                        if (k_reg == '0)
                        begin
                            row_count_reg <= '0;
                            fault_reg     <= 1'b0;
                        end
                    end
                end
                S_BSUB:
                begin
                    fault_reg     <= fault_reg | prod_sat.clamped | diff_sat.clamped;
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    a_reg    <= sub_diag;
                    b_reg    <= main_diag;
                    c_reg    <= last_eff ? '0 : super_diag;
                    r_reg    <= rhs_value;
                    last_reg <= last_eff;
                    i_reg    <= row_count_reg;
                end
            end
            S_MUL1:
            begin
                prod_reg <= a_reg * ms_rd_reg;
            end
            S_MUL2:
            begin
                pivot_reg <= diff_sat.value;
                prod_reg  <= a_reg * mr_rd_reg;
            end
            S_DIV:
            begin
                if (rsp_super.done)
                begin
                    out_sol_reg   <= rsp_rhs.quo;
                    next_sol_reg  <= rsp_rhs.quo;
                    out_idx_reg   <= i_reg;
                    k_reg         <= i_reg;
                    out_fault_reg <= fault_reg | rsp_super.sat | rsp_rhs.sat;
                end
            end
            S_OUT:
            begin
                if (out_acc && (k_reg != '0))
                begin
                    k_reg <= k_reg - 1'b1;
                end
            end
            S_BMUL:
            begin
                prod_reg <= ms_rd_reg * next_sol_reg;
            end
            S_BSUB:
            begin
                out_sol_reg   <= diff_sat.value;
                next_sol_reg  <= diff_sat.value;
                out_idx_reg   <= k_reg;
                out_fault_reg <= fault_reg | prod_sat.clamped | diff_sat.clamped;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign solution    = out_sol_reg;
    assign row_index   = tss_pkg::ROW_IDX_W'(out_idx_reg);
    assign last_result = (out_idx_reg == '0);
    assign pivot_fault = out_fault_reg;

endmodule

@@ rtl/tss_checker.sv @@
// Port-level checker for tridiagonal_system_solver_core, attached by bind.
// Depends on tss_pkg for field widths.
module tss_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [tss_pkg::DATA_W-1:0] solution,
    input logic [tss_pkg::ROW_IDX_W-1:0]     row_index,
    input logic                              last_result
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(solution) && $stable(row_index))
        else $error("Stalled result changed.");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("Request taken while a result is pending.");

    a_row_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("Result shown right after a request.");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_result |-> row_index == '0)
        else $error("Final result not at index zero.");

endmodule

bind tridiagonal_system_solver_core tss_checker u_tss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .solution    (solution),
    .row_index   (row_index),
    .last_result (last_result)
);

@@ tb/tridiagonal_system_solver_core_tb.sv @@
// Self-checking testbench for the Thomas tridiagonal solver core.
// Depends on tss_pkg and tridiagonal_system_solver_core; predicts every solution in Q16.16.
module tridiagonal_system_solver_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS  = 64;
    localparam int FRAC_BITS = 16;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        tss_pkg::fx_t                  solution;
        logic [tss_pkg::ROW_IDX_W-1:0] row_index;
        logic                          last_result;
        logic                          pivot_fault;
    } solution_t;

    class solution_scoreboard;
        tss_pkg::fx_t mod_super[MAX_ROWS];
        tss_pkg::fx_t mod_rhs[MAX_ROWS];
        int           rows_held;
        bit           fault;
        tss_pkg::fx_t prev_x;
        solution_t    pending[$];
        int           errors;

        function new();
            rows_held = 0;
            fault = 0;
            prev_x = '0;
            errors = 0;
        endfunction

        function tss_pkg::fx_t clamp(longint v);
            if (v > longint'(32'sh7fffffff))
            begin
                fault = 1;
                return 32'sh7fffffff;
            end
            if (v < -longint'(64'sh80000000))
            begin
                fault = 1;
                return 32'sh80000000;
            end
            return tss_pkg::fx_t'(v);
        endfunction

        function tss_pkg::fx_t fmul(tss_pkg::fx_t a, tss_pkg::fx_t b);
            longint p;
            p = longint'(a) * longint'(b);
            return clamp(p >>> FRAC_BITS);
        endfunction

        function tss_pkg::fx_t fsub(tss_pkg::fx_t a, tss_pkg::fx_t b);
            return clamp(longint'(a) - longint'(b));
        endfunction

        function tss_pkg::fx_t fdiv(tss_pkg::fx_t num, tss_pkg::fx_t den);
            if (den == 0)
            begin
                fault = 1;
                if (num > 0)
                    return 32'sh7fffffff;
                if (num < 0)
                    return 32'sh80000000;
                return '0;
            end
            return clamp((longint'(num) <<< FRAC_BITS) / longint'(den));
        endfunction

        function void note_row(tss_pkg::fx_t a, tss_pkg::fx_t b, tss_pkg::fx_t c,
                               tss_pkg::fx_t r, bit last);
            int           i;
            tss_pkg::fx_t pivot;
            tss_pkg::fx_t x;
            solution_t    s;
            i = rows_held;
            if (i > MAX_ROWS - 1)
                i = MAX_ROWS - 1;
            if (i == MAX_ROWS - 1 && !last)
            begin
                fault = 1;
                last = 1;
            end
            if (last)
                c = '0;
            if (i == 0)
            begin
                pivot = b;
                mod_super[0] = fdiv(c, pivot);
                mod_rhs[0] = fdiv(r, pivot);
            end
            else
            begin
                pivot = fsub(b, fmul(a, mod_super[i-1]));
                mod_super[i] = fdiv(c, pivot);
                mod_rhs[i] = fdiv(fsub(r, fmul(a, mod_rhs[i-1])), pivot);
            end
            if (!last)
            begin
                rows_held = i + 1;
                return;
            end
            for (int k = i; k >= 0; k--)
            begin
                if (k == i)
                    x = mod_rhs[k];
                else
                    x = fsub(mod_rhs[k], fmul(mod_super[k], prev_x));
                prev_x = x;
                s.solution = x;
                s.row_index = k[tss_pkg::ROW_IDX_W-1:0];
                s.last_result = (k == 0);
                s.pivot_fault = fault;
                pending.push_back(s);
            end
            rows_held = 0;
            fault = 0;
        endfunction

        task check_solution(solution_t got);
            solution_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result with no expectation", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.solution !== want.solution)
                report_mismatch("solution", got.solution, want.solution);
            if (got.row_index !== want.row_index)
                report_mismatch("row_index", got.row_index, want.row_index);
            if (got.last_result !== want.last_result)
                report_mismatch("last_result", got.last_result, want.last_result);
            if (got.pivot_fault !== want.pivot_fault)
                report_mismatch("pivot_fault", got.pivot_fault, want.pivot_fault);
        endtask

        task report_mismatch(string what, longint got, longint want);
            errors++;
            $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    tss_pkg::fx_t sub_diag;
    tss_pkg::fx_t main_diag;
    tss_pkg::fx_t super_diag;
    tss_pkg::fx_t rhs_value;
    logic last_row;
    logic out_valid;
    logic out_ready;
    tss_pkg::fx_t solution;
    logic [tss_pkg::ROW_IDX_W-1:0] row_index;
    logic last_result;
    logic pivot_fault;

    solution_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    longint cycles;

    tridiagonal_system_solver_core #(
        .MAX_ROWS(MAX_ROWS),
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sub_diag(sub_diag),
        .main_diag(main_diag),
        .super_diag(super_diag),
        .rhs_value(rhs_value),
        .last_row(last_row),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .solution(solution),
        .row_index(row_index),
        .last_result(last_result),
        .pivot_fault(pivot_fault)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_solution({solution, row_index, last_result, pivot_fault});
        if (!rst_n || hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_row(tss_pkg::fx_t a, tss_pkg::fx_t b, tss_pkg::fx_t c,
                            tss_pkg::fx_t r, bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sub_diag <= a;
        main_diag <= b;
        super_diag <= c;
        rhs_value <= r;
        last_row <= last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_row(a, b, c, r, last);
    endtask

    function automatic tss_pkg::fx_t rand_coef(bit wide);
        if (wide)
            return tss_pkg::fx_t'($urandom);
        return tss_pkg::fx_t'($urandom_range(32'h00040000)) - tss_pkg::fx_t'(32'h00020000);
    endfunction

    task automatic send_system(int n);
        tss_pkg::fx_t b;
        for (int i = 0; i < n; i++)
        begin
            b = rand_coef(0);
            if ($urandom_range(3) != 0)
                b = b + (b[31] ? -32'sh00060000 : 32'sh00060000);
            send_row(rand_coef($urandom_range(9) == 0), b,
                     rand_coef($urandom_range(9) == 0),
                     rand_coef($urandom_range(5) == 0), i == n - 1);
        end
    endtask

    task automatic run_random(int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            n = ($urandom_range(19) == 0) ? $urandom_range(64) + 1 : $urandom_range(8) + 1;
            send_system(n);
            sent += n;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        in_valid = 0;
        sub_diag = '0;
        main_diag = '0;
        super_diag = '0;
        rhs_value = '0;
        last_row = 0;
        out_ready = 0;
        hold_off = 0;
        send_idle_pct = 11;
        recv_idle_pct = 71;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_row(32'sh12345678, 32'sh00020000, 32'sh7fffffff, 32'sh00050000, 1);
        send_row('0, '0, '0, 32'sh00010000, 1);
        send_row('0, '0, '0, 32'sh80000000, 1);
        send_row('0, '0, '0, '0, 1);
        send_row('0, 32'sh00000001, '0, 32'sh7fffffff, 1);
        send_row(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
        send_row(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
        send_row(32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff, 1);
        send_row('0, 32'sh00010000, 32'sh00010000, 32'sh00010000, 0);
        send_row(32'sh00010000, 32'sh00010000, '0, 32'sh00020000, 1);
        for (int i = 0; i < 64; i++)
            send_row(32'shffff0000, 32'sh00040000, 32'shffff0000, tss_pkg::fx_t'($urandom), 0);
        drain();

        run_random(170);
        hold_off = 1;
        fork
            begin
                repeat (800) @(posedge clk);
                hold_off = 0;
            end
            begin
                send_system(6);
                send_system(4);
            end
        join
        drain();

        send_idle_pct = 71;
        recv_idle_pct = 11;
        run_random(160);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(160);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
